### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types for the point-in-polygon crossing test: sequencer states,
// edge selection and the parity mask.
// ----------------------------------------------------------------------------
package pip_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B
  } pip_state_t;

  // which edge the shared unit is working on
  typedef enum logic {
    EDGE_CHAIN,
    EDGE_CLOSE
  } pip_edge_sel_t;

  localparam logic PARITY_MASK = 1'b1;

endpackage

### rtl/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Crossing-number point-in-polygon test over a stream of vertex words.
// ----------------------------------------------------------------------------
// Vertices arrive one word each, in order; the word flagged first_vertex
// opens a polygon and latches the test point, the word flagged last_vertex
// closes it and yields one inside_res word (1 for an odd crossing count).
// Each edge is settled exactly by cross multiplication on one shared signed
// multiplier, two passes per edge, so a vertex is accepted and then makes
// both multiplier passes, a first vertex that is not also last is only
// accepted, and a last vertex runs its own edge and then the closing edge.
// The input is not ready while an edge is in progress; a finished result
// sits in an output register and does not hold up the next vertex unless a
// second result is ready before the first is taken.
module point_in_polygon_crossing_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_first_vertex,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res
);
  import pip_pkg::*;

  pip_state_t    state_r, state_nxt;
  pip_edge_sel_t sel_r;

  logic signed [COORD_WIDTH-1:0] test_x_r, test_y_r;
  logic signed [COORD_WIDTH-1:0] start_x_r, start_y_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_WIDTH-1:0] cur_x_r, cur_y_r;
  logic                          last_r;
  logic                          parity_r;
  logic                          out_valid_r;
  logic                          out_inside_r;

  logic signed [COORD_WIDTH-1:0] edge_x0, edge_y0, edge_x1, edge_y1;
  logic                          edge_count;
  logic                          in_fire;
  logic                          phase_b;
  logic                          commit;

  assign in_fire = in_valid & in_ready;

  // closing edge runs from the last vertex back to the first
  assign edge_x0 = (sel_r == EDGE_CLOSE) ? cur_x_r   : prev_x_r;
  assign edge_y0 = (sel_r == EDGE_CLOSE) ? cur_y_r   : prev_y_r;
  assign edge_x1 = (sel_r == EDGE_CLOSE) ? start_x_r : cur_x_r;
  assign edge_y1 = (sel_r == EDGE_CLOSE) ? start_y_r : cur_y_r;

  pip_edge #(
    .W(COORD_WIDTH)
  ) u_edge (
    .clk       (clk),
    .phase_b   (phase_b),
    .x0        (edge_x0),
    .y0        (edge_y0),
    .x1        (edge_x1),
    .y1        (edge_y1),
    .tx        (test_x_r),
    .ty        (test_y_r),
    .edge_count(edge_count)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_first_vertex && !in_last_vertex) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        if (!commit) begin
          state_nxt = ST_MUL_B;
        end else if (sel_r == EDGE_CHAIN && last_r) begin
          state_nxt = ST_MUL_A;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    phase_b  = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MUL_A: begin
        phase_b = 1'b0;
      end
      ST_MUL_B: begin
        phase_b = 1'b1;
        // a closing edge waits while the previous result is still held
        commit  = !(sel_r == EDGE_CLOSE && out_valid_r && !out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= EDGE_CHAIN;
      last_r      <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
      test_x_r    <= '0;
      test_y_r    <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      state_r <= state_nxt;
      // a new result may land in the same cycle the old one is taken
      if (state_r == ST_MUL_B && commit && sel_r == EDGE_CLOSE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && in_fire) begin
        last_r <= in_last_vertex;
        if (in_first_vertex) begin
          test_x_r  <= in_point_x;
          test_y_r  <= in_point_y;
          start_x_r <= in_vertex_x;
          start_y_r <= in_vertex_y;
          prev_x_r  <= in_vertex_x;
          prev_y_r  <= in_vertex_y;
          parity_r  <= 1'b0;
          sel_r     <= EDGE_CLOSE;
        end else begin
          sel_r <= EDGE_CHAIN;
        end
      end
      if (state_r == ST_MUL_B && commit) begin
        if (sel_r == EDGE_CHAIN) begin
          parity_r <= parity_r ^ edge_count;
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          sel_r    <= EDGE_CLOSE;
        end else begin
          parity_r <= 1'b0;
        end
      end
    end
  end

  // vertex and result words carry no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      cur_x_r <= in_vertex_x;
      cur_y_r <= in_vertex_y;
    end
    if (state_r == ST_MUL_B && commit && sel_r == EDGE_CLOSE) begin
      out_inside_r <= (parity_r ^ edge_count) & PARITY_MASK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

### rtl/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge
// Edge crossing evaluator. Decides in two passes through one shared signed
// multiplier whether an edge crosses the ray to the right of the test point.
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                phase_b,
  input  logic signed [W-1:0] x0,
  input  logic signed [W-1:0] y0,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] y1,
  input  logic signed [W-1:0] tx,
  input  logic signed [W-1:0] ty,
  output logic                edge_count
);
  import pip_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] diff_a, diff_b, diff_c, diff_e;
  logic signed [DW-1:0] mul_op0, mul_op1;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic                 ya, yb, xa, xb;
  logic                 p_ge, p_le, slope_hit;

  assign diff_a = $signed({x0[W-1], x0}) - $signed({tx[W-1], tx});
  assign diff_b = $signed({x1[W-1], x1}) - $signed({tx[W-1], tx});
  assign diff_c = $signed({y0[W-1], y0}) - $signed({ty[W-1], ty});
  assign diff_e = $signed({y1[W-1], y1}) - $signed({ty[W-1], ty});

  assign ya = (y0 >= ty);
  assign yb = (y1 >= ty);
  assign xa = (x0 >= tx);
  assign xb = (x1 >= tx);

  // first pass a*e, second pass c*b
  assign mul_op0 = phase_b ? diff_c : diff_a;
  assign mul_op1 = phase_b ? diff_b : diff_e;
  assign prod    = mul_op0 * mul_op1;

  always_ff @(posedge clk) begin
    if (!phase_b) begin
      prod_r <= prod;
    end
  end

  // sign of a*e - c*b against the direction of the edge in y
  assign p_ge      = (prod_r >= prod);
  assign p_le      = (prod_r <= prod);
  assign slope_hit = yb ? p_ge : p_le;

  always_comb begin
    if (ya == yb) begin
      edge_count = 1'b0;
    end else if (xa == xb) begin
      edge_count = xa & PARITY_MASK;
    end else begin
      edge_count = slope_hit;
    end
  end

endmodule

### tb/pip_crossing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pip_crossing_checker
// Watches the vertex and result channels of the point-in-polygon block,
// predicts each inside_res word from the accepted vertex words and compares
// it with what the block delivers.
// ----------------------------------------------------------------------------
module pip_crossing_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_first_vertex,
  input  logic                          in_last_vertex,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_inside_res,
  output int                            fail_count,
  output int                            pending
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  coord_t start_x, start_y, prev_x, prev_y, test_x, test_y;
  logic   odd_crossings;
  logic   inside_expected[$];
  int     errors = 0;

  // does the edge (x0,y0)-(x1,y1) cross the ray running right from the point
  function automatic logic edge_toggles(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    logic   up0, up1, right0, right1;
    longint dx0, dx1, dy0, dy1, det;
    up0    = y0 >= test_y;
    up1    = y1 >= test_y;
    right0 = x0 >= test_x;
    right1 = x1 >= test_x;
    if (up0 == up1) return 1'b0;
    if (right0 == right1) return right0;
    dx0 = longint'(x0) - longint'(test_x);
    dx1 = longint'(x1) - longint'(test_x);
    dy0 = longint'(y0) - longint'(test_y);
    dy1 = longint'(y1) - longint'(test_y);
    // crossing x minus point x has the sign of det over (dy1 - dy0)
    det = dx0 * dy1 - dy0 * dx1;
    return up1 ? (det >= 0) : (det <= 0);
  endfunction

  always @(posedge clk) begin
    logic expected_bit;
    logic parity;
    if (!rst_n) begin
      start_x = '0;
      start_y = '0;
      prev_x = '0;
      prev_y = '0;
      test_x = '0;
      test_y = '0;
      odd_crossings = 1'b0;
      inside_expected.delete();
    end else begin
      // a result word always stems from an earlier vertex word
      if (out_valid && out_ready) begin
        if (inside_expected.size() == 0) begin
          $display("%0t: unexpected inside_res word, expected none, got %0b",
                   $time, out_inside_res);
          errors++;
        end else begin
          expected_bit = inside_expected.pop_front();
          if (out_inside_res !== expected_bit) begin
            $display("%0t: inside_res mismatch, expected %0b, got %0b",
                     $time, expected_bit, out_inside_res);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        parity = odd_crossings;
        if (in_first_vertex) begin
          test_x = in_point_x;
          test_y = in_point_y;
          start_x = in_vertex_x;
          start_y = in_vertex_y;
          parity = 1'b0;
        end else begin
          parity ^= edge_toggles(prev_x, prev_y, in_vertex_x, in_vertex_y);
        end
        prev_x = in_vertex_x;
        prev_y = in_vertex_y;
        if (in_last_vertex) begin
          parity ^= edge_toggles(in_vertex_x, in_vertex_y, start_x, start_y);
          inside_expected.push_back(parity);
          parity = 1'b0;
        end
        odd_crossings = parity;
      end
    end
    fail_count <= errors;
    pending <= inside_expected.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives polygons through the point-in-polygon crossing test block and
// gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run covers extreme coordinates, one- and two-vertex
// polygons, points on edges and vertices, horizontal edges and vertex words
// that arrive with no polygon open. Random polygons follow in three idling
// phases, with one long result stall and drains between phases; the checker
// beside the block predicts and compares every result word.
module testbench;

  localparam int COORD_WIDTH     = 16;
  localparam int COORD_MIN       = -(2 ** (COORD_WIDTH - 1));
  localparam int COORD_MAX       = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int WORDS_PER_PHASE = 600;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 20;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_LO = coord_t'(COORD_MIN);
  localparam coord_t COORD_HI = coord_t'(COORD_MAX);

  // how polygon coordinates are spread
  typedef enum int {
    SPREAD_NEAR,
    SPREAD_FULL,
    SPREAD_CORNER
  } spread_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_vertex_x, in_vertex_y, in_point_x, in_point_y;
  logic   in_first_vertex, in_last_vertex;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_inside_res;

  int     fail_count;
  int     pending;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  logic   rx_hold_go = 1'b0;
  int     words_sent = 0;

  always #10 clk = ~clk;

  point_in_polygon_crossing_test #(
    .COORD_WIDTH(COORD_WIDTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_first_vertex(in_first_vertex),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

  pip_crossing_checker #(
    .COORD_WIDTH(COORD_WIDTH)
  ) crossing_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_first_vertex(in_first_vertex),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // result side: random stalls plus one long hold-off
  int   hold_left = 0;
  logic hold_used = 1'b0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_hold_go && !hold_used) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coord_t pick_coord(spread_t spread, coord_t center, int span);
    int v;
    case (spread)
      SPREAD_NEAR: begin
        v = int'(center) + (int'($urandom_range(2 * span)) - span);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
      end
      SPREAD_FULL: v = int'(coord_t'($urandom));
      default: begin
        case ($urandom_range(6))
          0: v = COORD_MIN;
          1: v = COORD_MIN + 1;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = COORD_MAX - 1;
          default: v = COORD_MAX;
        endcase
      end
    endcase
    return coord_t'(v);
  endfunction

  task automatic send_word(coord_t vx, coord_t vy, coord_t px, coord_t py,
                           logic first, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_x <= vx;
    in_vertex_y <= vy;
    in_point_x <= px;
    in_point_y <= py;
    in_first_vertex <= first;
    in_last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_polygon();
    spread_t spread;
    int      span, count, roll;
    coord_t  px, py;
    logic    drop_first, drop_last, first, last;
    roll = $urandom_range(99);
    spread = roll < 60 ? SPREAD_NEAR : (roll < 85 ? SPREAD_FULL : SPREAD_CORNER);
    case ($urandom_range(2))
      0: span = 3;
      1: span = 60;
      default: span = 3000;
    endcase
    roll = $urandom_range(9);
    count = roll == 0 ? 1 : (roll == 1 ? 2 : int'($urandom_range(3, 8)));
    // a few broken polygons: no opening word or no closing word
    roll = $urandom_range(19);
    drop_first = roll == 0;
    drop_last = roll == 1;
    px = pick_coord(spread == SPREAD_NEAR ? SPREAD_FULL : spread, '0, span);
    py = pick_coord(spread == SPREAD_NEAR ? SPREAD_FULL : spread, '0, span);
    for (int i = 0; i < count; i++) begin
      first = (i == 0) && !drop_first;
      last = (i == count - 1) && !drop_last;
      send_word(pick_coord(spread, px, span), pick_coord(spread, py, span),
                first ? px : coord_t'($urandom), first ? py : coord_t'($urandom),
                first, last);
    end
  endtask

  initial begin
    int phase_start;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_vertex_x <= '0;
    in_vertex_y <= '0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_first_vertex <= 1'b0;
    in_last_vertex <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 21;
    rx_idle_pct <= 77;

    // chain with no polygon opened since reset
    send_word(10, -10, 123, -45, 1'b0, 1'b0);
    send_word(-10, 10, 0, 0, 1'b0, 1'b1);
    // one-vertex polygon
    send_word(100, 100, 100, 100, 1'b1, 1'b1);
    // square around the point
    send_word(-10, -10, 0, 0, 1'b1, 1'b0);
    send_word(10, -10, 0, 0, 1'b0, 1'b0);
    send_word(10, 10, 0, 0, 1'b0, 1'b0);
    send_word(-10, 10, 0, 0, 1'b0, 1'b1);
    // vertex words right after a closed polygon
    send_word(20, 0, 0, 0, 1'b0, 1'b0);
    send_word(30, 30, 0, 0, 1'b0, 1'b1);
    // extreme coordinates
    send_word(COORD_LO, COORD_LO, 0, 0, 1'b1, 1'b0);
    send_word(COORD_HI, COORD_LO, 0, 0, 1'b0, 1'b0);
    send_word(0, COORD_HI, 0, 0, 1'b0, 1'b1);
    send_word(COORD_LO, COORD_LO, COORD_HI, COORD_LO, 1'b1, 1'b0);
    send_word(COORD_HI, COORD_HI, COORD_LO, COORD_HI, 1'b0, 1'b0);
    send_word(COORD_LO, COORD_HI, 0, 0, 1'b0, 1'b1);
    // point lies on a diagonal edge
    send_word(-5, -5, 0, 0, 1'b1, 1'b0);
    send_word(5, 5, 0, 0, 1'b0, 1'b0);
    send_word(5, -5, 0, 0, 1'b0, 1'b1);
    // two-vertex polygon
    send_word(-3, -4, 1, 0, 1'b1, 1'b0);
    send_word(7, 6, 0, 0, 1'b0, 1'b1);
    // horizontal edge through the point
    send_word(-5, 0, 0, 0, 1'b1, 1'b0);
    send_word(5, 0, 0, 0, 1'b0, 1'b0);
    send_word(0, 5, 0, 0, 1'b0, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct <= 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct <= 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        // long result stall while words keep coming
        if (ph == 2 && words_sent - phase_start >= 60) rx_hold_go <= 1'b1;
        if ($urandom_range(19) == 0) begin
          send_word(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          send_polygon();
        end
      end
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
